// File: hw/rtl/string_literal_unescaper_assert.svh
// ----------------------------------------------------------------------------
// String literal unescaper assertion macros
// Shared forms for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef STRING_LITERAL_UNESCAPER_ASSERT_SVH
`define STRING_LITERAL_UNESCAPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/slu_pkg.sv
// ----------------------------------------------------------------------------
// String literal unescaper package
// Types, codes and character helpers shared by the unescaper modules.
// ----------------------------------------------------------------------------
package slu_pkg;

   typedef enum logic [2:0] {
      MODE_OPEN  = 3'd0,
      MODE_STR   = 3'd1,
      MODE_ESC   = 3'd2,
      MODE_HEX1  = 3'd3,
      MODE_HEX2  = 3'd4,
      MODE_AFTER = 3'd5
   } mode_type;

   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_END     = 2'd1;
   localparam logic [1:0] KIND_NOQUOTE = 2'd2;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_LF        = 8'h0A;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [7:0] data;
      logic       hex_error;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] nibble;
   } hex_digit_type;

   function automatic hex_digit_type hex_value(input logic [7:0] b);
      hex_digit_type h;
      h.valid  = 1'b1;
      h.nibble = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.nibble = b[3:0];
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         h.nibble = b[3:0] + 4'd9;
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_CR || b == CHAR_LF;
   endfunction

   function automatic logic [7:0] unescape(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         8'h6E: begin
            r = 8'h0A;
         end
         8'h72: begin
            r = 8'h0D;
         end
         8'h74: begin
            r = 8'h09;
         end
         8'h76: begin
            r = 8'h0B;
         end
         8'h61: begin
            r = 8'h07;
         end
         8'h66: begin
            r = 8'h0C;
         end
         8'h30: begin
            r = 8'h00;
         end
         default: begin
            r = b;
         end
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/slu_decode.sv
// ----------------------------------------------------------------------------
// String literal unescaper decoder
// Holds the literal's mode and hex nibble and decodes one byte per step.
// ----------------------------------------------------------------------------
module slu_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         in_byte,
   output slu_pkg::result_type result
);

   slu_pkg::mode_type mode_ff, mode_in;
   logic [3:0]        hex_high_ff, hex_high_in;
   slu_pkg::hex_digit_type digit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= slu_pkg::MODE_OPEN;
         hex_high_ff <= 4'd0;
      end else if (step) begin
         mode_ff     <= mode_in;
         hex_high_ff <= hex_high_in;
      end
   end

   always_comb begin
      digit       = slu_pkg::hex_value(in_byte);
      mode_in     = mode_ff;
      hex_high_in = hex_high_ff;
      result      = '{valid: 1'b0, kind: slu_pkg::KIND_BYTE, data: in_byte, hex_error: 1'b0};
      case (mode_ff)
         slu_pkg::MODE_STR: begin
            if (in_byte == slu_pkg::CHAR_QUOTE) begin
               mode_in = slu_pkg::MODE_AFTER;
            end else if (in_byte == slu_pkg::CHAR_BACKSLASH) begin
               mode_in = slu_pkg::MODE_ESC;
            end else begin
               result.valid = 1'b1;
            end
         end
         slu_pkg::MODE_ESC: begin
            if (in_byte == slu_pkg::CHAR_X) begin
               mode_in = slu_pkg::MODE_HEX1;
            end else begin
               mode_in      = slu_pkg::MODE_STR;
               result.valid = 1'b1;
               result.data  = slu_pkg::unescape(in_byte);
            end
         end
         slu_pkg::MODE_HEX1: begin
            if (digit.valid) begin
               hex_high_in = digit.nibble;
               mode_in     = slu_pkg::MODE_HEX2;
            end else begin
               mode_in          = slu_pkg::MODE_STR;
               result.valid     = 1'b1;
               result.data      = slu_pkg::CHAR_X;
               result.hex_error = 1'b1;
            end
         end
         slu_pkg::MODE_HEX2: begin
            mode_in      = slu_pkg::MODE_STR;
            result.valid = 1'b1;
            if (digit.valid) begin
               result.data = {hex_high_ff, digit.nibble};
            end else begin
               result.data      = {hex_high_ff, 4'd0};
               result.hex_error = 1'b1;
            end
         end
         slu_pkg::MODE_AFTER: begin
            if (in_byte == slu_pkg::CHAR_QUOTE) begin
               mode_in = slu_pkg::MODE_STR;
            end else if (!slu_pkg::is_space(in_byte)) begin
               mode_in      = slu_pkg::MODE_OPEN;
               result.valid = 1'b1;
               result.kind  = slu_pkg::KIND_END;
            end
         end
         default: begin
            if (in_byte == slu_pkg::CHAR_QUOTE) begin
               mode_in = slu_pkg::MODE_STR;
            end else begin
               mode_in      = slu_pkg::MODE_OPEN;
               result.valid = 1'b1;
               result.kind  = slu_pkg::KIND_NOQUOTE;
            end
         end
      endcase
   end

endmodule

// File: hw/rtl/slu_rsp_reg.sv
// ----------------------------------------------------------------------------
// String literal unescaper result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module slu_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  slu_pkg::result_type result,
   output logic                ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_data,
   output logic                rsp_hex_error
);

   logic       valid_ff;
   logic [1:0] kind_ff;
   logic [7:0] data_ff;
   logic       hex_error_ff;

   assign ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && load) begin
         kind_ff      <= result.kind;
         data_ff      <= result.data;
         hex_error_ff <= result.hex_error;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_data      = data_ff;
   assign rsp_hex_error = hex_error_ff;

endmodule

// File: hw/rtl/string_literal_unescaper.sv
// ----------------------------------------------------------------------------
// String literal unescaper
// Decodes a double-quoted string literal from a stream of source bytes.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle and each gives zero or one result word,
// which passes from the input register through the mode update into the
// result register and onto the result ports; the rate is set by the mode
// update between the input register and the result register, and it holds
// at one byte per cycle while the result side keeps taking words. A stalled
// result word stalls a waiting input byte in the same cycle.
module string_literal_unescaper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic       rsp_hex_error
);

   logic                byte_valid_ff;
   logic [7:0]          byte_ff;
   logic                out_ready;
   logic                step;
   slu_pkg::result_type result;

   assign step      = byte_valid_ff && out_ready;
   assign req_stall = byte_valid_ff && !out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         byte_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_in_byte;
      end
   end

   slu_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (byte_ff),
      .result  (result)
   );

   slu_rsp_reg u_rsp_reg (
      .clock         (clock),
      .reset         (reset),
      .load          (step && result.valid),
      .result        (result),
      .ready         (out_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_data      (rsp_data),
      .rsp_hex_error (rsp_hex_error)
   );

endmodule

// File: hw/rtl/slu_checker.sv
// ----------------------------------------------------------------------------
// String literal unescaper checker
// Port-level checks on the result words, bound to the top level.
// ----------------------------------------------------------------------------
`include "string_literal_unescaper_assert.svh"

module slu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_data,
   input logic       rsp_hex_error
);

   logic        kind_known;
   logic        src_taken;
   logic [10:0] rsp_word;

   assign kind_known = rsp_kind == slu_pkg::KIND_BYTE || rsp_kind == slu_pkg::KIND_END
                       || rsp_kind == slu_pkg::KIND_NOQUOTE;
   assign src_taken  = req_valid && !req_stall;
   assign rsp_word   = {rsp_kind, rsp_data, rsp_hex_error};

   `SLU_ASSERT_IMPLY(a_kind_known, clock, reset, rsp_valid, kind_known, "unknown result kind")
   `SLU_ASSERT_IMPLY(a_hex_error_byte, clock, reset, rsp_valid && rsp_hex_error, rsp_kind == slu_pkg::KIND_BYTE, "hex error on a non-byte word")
   `SLU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "stalled result word changed")
   `SLU_ASSERT_IMPLY(a_rsp_has_source, clock, reset, $rose(rsp_valid), $past(src_taken, 2), "result word without a source byte")

endmodule

bind string_literal_unescaper slu_checker u_slu_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String literal unescaper testbench
// A short table of directed source bytes is followed by randomly built string
// tokens. Every accepted byte is run through a behavioural decoder, and each
// result word is checked against the oldest word the rows or decoder predict.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       hex_error;
   } decoded_word_type;

   typedef struct {
      logic [7:0]       src;
      bit               typed;
      decoded_word_type word;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data;
   logic       rsp_hex_error;

   slu_pkg::mode_type lex_mode = slu_pkg::MODE_OPEN;
   logic [3:0]        hex_high = 4'h0;
   decoded_word_type  expected_words [$];
   stim_row_type      directed_rows [$];
   logic [7:0]        source_stream [$];
   logic [7:0]        escape_letters [9] = '{"n", "r", "t", "v", slu_pkg::CHAR_BACKSLASH,
                                             "a", "f", "0", slu_pkg::CHAR_QUOTE};
   logic [7:0]        blank_chars [4] = '{slu_pkg::CHAR_SPACE, slu_pkg::CHAR_TAB,
                                          slu_pkg::CHAR_CR, slu_pkg::CHAR_LF};
   bit                send_idle = 1'b1;
   int                mismatches = 0;
   int                bytes_sent = 0;
   int                decoded_count = 0;
   int                end_count = 0;
   int                noquote_count = 0;
   int                hex_error_count = 0;

   always #2 clock = ~clock;

   string_literal_unescaper uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_data(rsp_data),
      .rsp_hex_error(rsp_hex_error)
   );

   function automatic bit is_blank(input logic [7:0] b);
      return b == slu_pkg::CHAR_SPACE || b == slu_pkg::CHAR_TAB || b == slu_pkg::CHAR_CR
             || b == slu_pkg::CHAR_LF;
   endfunction

   function automatic bit hex_nibble(input logic [7:0] b, output logic [3:0] nib);
      nib = 4'h0;
      if (b >= "0" && b <= "9") begin
         nib = 4'(b - "0");
      end else if (b >= "a" && b <= "f") begin
         nib = 4'(b - "a" + 10);
      end else if (b >= "A" && b <= "F") begin
         nib = 4'(b - "A" + 10);
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [7:0] escaped_value(input logic [7:0] b);
      case (b)
         "n": return 8'h0A;
         "r": return 8'h0D;
         "t": return 8'h09;
         "v": return 8'h0B;
         "a": return 8'h07;
         "f": return 8'h0C;
         "0": return 8'h00;
         default: return b;
      endcase
   endfunction

   // Advances the decoder by one source byte; returns 1 when a word is due.
   function automatic bit decode_byte(input logic [7:0] b, output decoded_word_type w);
      logic [3:0] nib;
      bit         ok;
      w.kind = slu_pkg::KIND_BYTE;
      w.data = b;
      w.hex_error = 1'b0;
      case (lex_mode)
         slu_pkg::MODE_STR: begin
            if (b == slu_pkg::CHAR_QUOTE) begin
               lex_mode = slu_pkg::MODE_AFTER;
               return 1'b0;
            end
            if (b == slu_pkg::CHAR_BACKSLASH) begin
               lex_mode = slu_pkg::MODE_ESC;
               return 1'b0;
            end
            return 1'b1;
         end
         slu_pkg::MODE_ESC: begin
            if (b == slu_pkg::CHAR_X) begin
               lex_mode = slu_pkg::MODE_HEX1;
               return 1'b0;
            end
            lex_mode = slu_pkg::MODE_STR;
            w.data = escaped_value(b);
            return 1'b1;
         end
         slu_pkg::MODE_HEX1: begin
            ok = hex_nibble(b, nib);
            if (ok) begin
               hex_high = nib;
               lex_mode = slu_pkg::MODE_HEX2;
               return 1'b0;
            end
            lex_mode = slu_pkg::MODE_STR;
            w.data = slu_pkg::CHAR_X;
            w.hex_error = 1'b1;
            return 1'b1;
         end
         slu_pkg::MODE_HEX2: begin
            ok = hex_nibble(b, nib);
            lex_mode = slu_pkg::MODE_STR;
            w.data = {hex_high, ok ? nib : 4'h0};
            w.hex_error = !ok;
            return 1'b1;
         end
         slu_pkg::MODE_AFTER: begin
            if (is_blank(b)) begin
               return 1'b0;
            end
            if (b == slu_pkg::CHAR_QUOTE) begin
               lex_mode = slu_pkg::MODE_STR;
               return 1'b0;
            end
            lex_mode = slu_pkg::MODE_OPEN;
            w.kind = slu_pkg::KIND_END;
            return 1'b1;
         end
         default: begin
            if (b == slu_pkg::CHAR_QUOTE) begin
               lex_mode = slu_pkg::MODE_STR;
               return 1'b0;
            end
            lex_mode = slu_pkg::MODE_OPEN;
            w.kind = slu_pkg::KIND_NOQUOTE;
            return 1'b1;
         end
      endcase
   endfunction

   task automatic add_row(input logic [7:0] b, input bit typed, input logic [1:0] kind,
                          input logic [7:0] data, input logic herr);
      stim_row_type r;
      r.src = b;
      r.typed = typed;
      r.word.kind = kind;
      r.word.data = data;
      r.word.hex_error = herr;
      directed_rows.push_back(r);
   endtask

   function automatic logic [7:0] hex_or_noise();
      int p;
      if ($urandom_range(0, 19) < 3) begin
         return 8'($urandom_range(0, 255));
      end
      p = $urandom_range(0, 21);
      if (p < 10) begin
         return 8'("0" + p);
      end else if (p < 16) begin
         return 8'("a" + p - 10);
      end
      return 8'("A" + p - 16);
   endfunction

   task automatic build_token();
      int         pick;
      logic [7:0] t;
      if ($urandom_range(0, 9) == 0) begin
         source_stream.push_back(8'($urandom_range(0, 255)));
         return;
      end
      do begin
         source_stream.push_back(slu_pkg::CHAR_QUOTE);
         repeat ($urandom_range(0, 12)) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               source_stream.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 8) begin
               source_stream.push_back(slu_pkg::CHAR_BACKSLASH);
               pick = $urandom_range(0, 9);
               source_stream.push_back(pick < 9 ? escape_letters[pick]
                                                : 8'($urandom_range(0, 255)));
            end else begin
               source_stream.push_back(slu_pkg::CHAR_BACKSLASH);
               source_stream.push_back(slu_pkg::CHAR_X);
               source_stream.push_back(hex_or_noise());
               source_stream.push_back(hex_or_noise());
            end
         end
         // An unterminated literal swallows whatever follows it.
         if ($urandom_range(0, 19) == 0) begin
            return;
         end
         source_stream.push_back(slu_pkg::CHAR_QUOTE);
         repeat ($urandom_range(0, 3)) begin
            source_stream.push_back(blank_chars[$urandom_range(0, 3)]);
         end
      end while ($urandom_range(0, 3) == 0);
      t = 8'($urandom_range(0, 255));
      if (is_blank(t) || t == slu_pkg::CHAR_QUOTE) begin
         t = ";";
      end
      source_stream.push_back(t);
   endtask

   task automatic send_byte(input logic [7:0] b, input bit typed,
                            input decoded_word_type typed_word);
      decoded_word_type w;
      int               gap;
      gap = send_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do begin
         @(posedge clock);
      end while (req_stall);
      if (decode_byte(b, w)) begin
         expected_words.push_back(typed ? typed_word : w);
      end
      bytes_sent++;
      if (bytes_sent % 97 == 0) begin
         send_idle = ($urandom_range(0, 3) != 0);
      end
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (expected_words.size() != 0);
   endtask

   task automatic note_mismatch(input string what, input decoded_word_type want,
                                input decoded_word_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s: expected kind %0d data %02h hex_error %0b,",
                  $realtime, what, want.kind, want.data, want.hex_error);
         $display("   got kind %0d data %02h hex_error %0b",
                  got.kind, got.data, got.hex_error);
      end
   endtask

   always @(posedge clock) begin : result_check
      decoded_word_type got;
      decoded_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_kind;
         got.data = rsp_data;
         got.hex_error = rsp_hex_error;
         if (got.kind == slu_pkg::KIND_BYTE) begin
            decoded_count++;
         end else if (got.kind == slu_pkg::KIND_END) begin
            end_count++;
         end else if (got.kind == slu_pkg::KIND_NOQUOTE) begin
            noquote_count++;
         end
         if (got.hex_error) begin
            hex_error_count++;
         end
         if (expected_words.size() == 0) begin
            note_mismatch("unexpected word", '0, got);
         end else begin
            want = expected_words.pop_front();
            if (got != want) begin
               note_mismatch("word mismatch", want, got);
            end
         end
      end
   end

   initial begin : result_sink
      int gap;
      int taken;
      bit idle_on;
      taken = 0;
      idle_on = 1'b1;
      while (reset) @(posedge clock);
      forever begin
         gap = idle_on ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do begin
            @(posedge clock);
         end while (!(rsp_valid && !rsp_stall));
         taken++;
         if (taken % 89 == 0) begin
            idle_on = ($urandom_range(0, 3) != 0);
         end
      end
   end

   initial begin : watchdog
      #2000000;
      $display("string_literal_unescaper verification failed");
      $finish;
   end

   initial begin : stimulus
      decoded_word_type none;
      none = '0;
      // A token that does not open with a quote, at both byte extremes.
      add_row(8'h00, 1'b1, slu_pkg::KIND_NOQUOTE, 8'h00, 1'b0);
      add_row(8'hFF, 1'b1, slu_pkg::KIND_NOQUOTE, 8'hFF, 1'b0);
      add_row(slu_pkg::CHAR_QUOTE, 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row("A", 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row(8'hFF, 1'b1, slu_pkg::KIND_BYTE, 8'hFF, 1'b0);
      add_row(slu_pkg::CHAR_BACKSLASH, 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row("n", 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      // A bad first hex digit yields the letter x.
      add_row(slu_pkg::CHAR_BACKSLASH, 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row(slu_pkg::CHAR_X, 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row("z", 1'b1, slu_pkg::KIND_BYTE, slu_pkg::CHAR_X, 1'b1);
      // A bad second hex digit yields the high nibble alone.
      add_row(slu_pkg::CHAR_BACKSLASH, 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row(slu_pkg::CHAR_X, 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row("F", 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row("g", 1'b1, slu_pkg::KIND_BYTE, 8'hF0, 1'b1);
      add_row(slu_pkg::CHAR_BACKSLASH, 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row(slu_pkg::CHAR_X, 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row("a", 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row("0", 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      // Close, skip blanks, join a second literal, then end the token.
      add_row(slu_pkg::CHAR_QUOTE, 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row(slu_pkg::CHAR_SPACE, 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row(slu_pkg::CHAR_TAB, 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row(slu_pkg::CHAR_QUOTE, 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row(slu_pkg::CHAR_QUOTE, 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row(slu_pkg::CHAR_LF, 1'b0, slu_pkg::KIND_BYTE, 8'h00, 1'b0);
      add_row("q", 1'b1, slu_pkg::KIND_END, "q", 1'b0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].src, directed_rows[i].typed, directed_rows[i].word);
      end
      drain_words();

      while (source_stream.size() < 1200) begin
         build_token();
      end
      foreach (source_stream[i]) begin
         if (i == 600) begin
            drain_words();
         end
         send_byte(source_stream[i], 1'b0, none);
      end
      drain_words();
      repeat (10) @(posedge clock);

      $display("Sent %0d source bytes (%0d directed) and checked the result words:",
               bytes_sent, directed_rows.size());
      $display("%0d decoded bytes (%0d with a bad hex digit), %0d token ends, %0d missing quotes.",
               decoded_count, hex_error_count, end_count, noquote_count);
      if (mismatches == 0) begin
         $display("string_literal_unescaper verification clean");
      end else begin
         $display("string_literal_unescaper verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/slu_pkg.sv
hw/rtl/slu_decode.sv
hw/rtl/slu_rsp_reg.sv
hw/rtl/string_literal_unescaper.sv
hw/rtl/slu_checker.sv
dv/tb_top.sv
